// ===== rtl/core/pgts_pkg.sv =====
// pgts_pkg: shared constants, codes and the queue entry type of the probe grid sampler
// no dependencies; imported by the front, queue, back and top-level modules

package pgts_pkg;

   // grid geometry
   localparam int GRID_X     = 16;
   localparam int GRID_Y     = 16;
   localparam int GRID_Z     = 16;
   localparam int DIRECTIONS = 8;

   localparam int GRID_MAX_XY = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
   localparam int GRID_MAX    = (GRID_MAX_XY > GRID_Z) ? GRID_MAX_XY : GRID_Z;
   localparam int COORD_W     = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;

   // field widths
   localparam int POS_W   = 32;
   localparam int CPU_W   = 24;
   localparam int CHAN_W  = 5;
   localparam int PROBE_W = 12;
   localparam int VALUE_W = 16;
   localparam int FRAC_W  = 16;
   localparam int ADDR_W  = PROBE_W + CHAN_W;
   localparam int STORE_DEPTH = 1 << ADDR_W;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CPU_X    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CPU_Y    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CPU_Z    = 3'd5;

   localparam logic [CPU_W-1:0] CPU_RESET = 24'h010000;

   // request kinds
   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   // command queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic                             kind;
      logic [CHAN_W-1:0]                chan;
      logic [PROBE_W-1:0]               probe_index;
      logic signed [VALUE_W-1:0]        write_value;
      logic [2:0][COORD_W-1:0]          lo;
      logic [2:0][COORD_W-1:0]          hi;
      logic [2:0][FRAC_W-1:0]           frac;
   } pgts_cmd_type;

endpackage

// ===== rtl/core/pgts_front.sv =====
// pgts_front: configuration registers, request intake and grid-coordinate setup
// depends on pgts_pkg; feeds classified commands into pgts_queue

module pgts_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_en,
   input  logic [pgts_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pgts_pkg::CSR_DATA_W-1:0]        csr_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_kind,
   input  logic signed [pgts_pkg::POS_W-1:0]      req_pos_x,
   input  logic signed [pgts_pkg::POS_W-1:0]      req_pos_y,
   input  logic signed [pgts_pkg::POS_W-1:0]      req_pos_z,
   input  logic [pgts_pkg::CHAN_W-1:0]            req_channel,
   input  logic [pgts_pkg::PROBE_W-1:0]           req_probe_index,
   input  logic signed [pgts_pkg::VALUE_W-1:0]    req_write_value,
   output logic                                   push,
   output pgts_pkg::pgts_cmd_type                 push_data,
   input  logic                                   full
);
   import pgts_pkg::*;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIFF,
      F_MUL,
      F_PUSH
   } front_state_type;

   localparam logic [8:0] SIZE_X = 9'(GRID_X);
   localparam logic [8:0] SIZE_Y = 9'(GRID_Y);
   localparam logic [8:0] SIZE_Z = 9'(GRID_Z);
   localparam logic signed [57:0] HALF = 58'sh80000000;

   function automatic logic [COORD_W-1:0] clamp_axis(input logic signed [26:0] c,
                                                     input logic [8:0] size);
      logic signed [26:0] top;
      top = $signed({18'd0, size - 9'd1});
      if (c < 27'sd0) begin
         return '0;
      end else if (c > top) begin
         return COORD_W'(size - 9'd1);
      end else begin
         return COORD_W'(c);
      end
   endfunction

   front_state_type state_ff, state_in;
   logic [1:0]  step_ff, step_in;

   logic signed [POS_W-1:0] origin_ff [3];
   logic [CPU_W-1:0]        cpu_ff [3];

   logic signed [POS_W-1:0] pos_ff [3];
   logic signed [POS_W:0]   diff_ff [3];
   logic signed [57:0]      prod_ff, prod_in;
   logic [COORD_W-1:0]      lo_ff [3];
   logic [COORD_W-1:0]      hi_ff [3];
   logic [FRAC_W-1:0]       frac_ff [3];
   logic                    kind_ff;
   logic [CHAN_W-1:0]       chan_ff;
   logic [PROBE_W-1:0]      pidx_ff;
   logic signed [VALUE_W-1:0] wval_ff;

   logic                    accept;
   logic signed [POS_W:0]   diff_sel;
   logic [CPU_W-1:0]        cpu_sel;
   logic signed [57:0]      prod_mul;
   logic [1:0]              clamp_axis_idx;
   logic [8:0]              clamp_size;
   logic signed [26:0]      cell_lo, cell_hi;

   assign req_stall = (state_ff != F_IDLE);
   assign accept    = req_valid && !req_stall;
   assign push      = (state_ff == F_PUSH) && !full;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            origin_ff[a] <= '0;
            cpu_ff[a]    <= CPU_RESET;
         end
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ORIGIN_X: origin_ff[0] <= $signed(csr_data);
            CSR_ORIGIN_Y: origin_ff[1] <= $signed(csr_data);
            CSR_ORIGIN_Z: origin_ff[2] <= $signed(csr_data);
            CSR_CPU_X:    cpu_ff[0]    <= csr_data[CPU_W-1:0];
            CSR_CPU_Y:    cpu_ff[1]    <= csr_data[CPU_W-1:0];
            CSR_CPU_Z:    cpu_ff[2]    <= csr_data[CPU_W-1:0];
            default: ;
         endcase
      end
   end

   // one shared multiplier, one axis per cycle
   always_comb begin
      unique case (step_ff)
         2'd0:    begin diff_sel = diff_ff[0]; cpu_sel = cpu_ff[0]; end
         2'd1:    begin diff_sel = diff_ff[1]; cpu_sel = cpu_ff[1]; end
         default: begin diff_sel = diff_ff[2]; cpu_sel = cpu_ff[2]; end
      endcase
   end

   assign prod_mul = diff_sel * $signed({1'b0, cpu_sel});
   assign prod_in  = prod_mul + HALF;

   // clamp the axis multiplied in the previous cycle
   assign clamp_axis_idx = step_ff - 2'd1;

   always_comb begin
      unique case (clamp_axis_idx)
         2'd0:    clamp_size = SIZE_X;
         2'd1:    clamp_size = SIZE_Y;
         default: clamp_size = SIZE_Z;
      endcase
   end

   assign cell_lo = {prod_ff[57], prod_ff[57:32]};
   assign cell_hi = cell_lo + 27'sd1;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = (req_kind == KIND_SAMPLE) ? F_DIFF : F_PUSH;
            end
         end
         F_DIFF: begin
            state_in = F_MUL;
            step_in  = 2'd0;
         end
         F_MUL: begin
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_kind;
         chan_ff   <= req_channel;
         pidx_ff   <= req_probe_index;
         wval_ff   <= req_write_value;
         pos_ff[0] <= req_pos_x;
         pos_ff[1] <= req_pos_y;
         pos_ff[2] <= req_pos_z;
      end
      if (state_ff == F_DIFF) begin
         for (int a = 0; a < 3; a++) begin
            diff_ff[a] <= {pos_ff[a][POS_W-1], pos_ff[a]}
                        - {origin_ff[a][POS_W-1], origin_ff[a]};
         end
      end
      if (state_ff == F_MUL) begin
         if (step_ff != 2'd3) begin
            prod_ff <= prod_in;
         end
         if (step_ff != 2'd0) begin
            lo_ff[clamp_axis_idx]   <= clamp_axis(cell_lo, clamp_size);
            hi_ff[clamp_axis_idx]   <= clamp_axis(cell_hi, clamp_size);
            frac_ff[clamp_axis_idx] <= prod_ff[31:16];
         end
      end
   end

   always_comb begin
      push_data.kind        = kind_ff;
      push_data.chan        = chan_ff;
      push_data.probe_index = pidx_ff;
      push_data.write_value = wval_ff;
      for (int a = 0; a < 3; a++) begin
         push_data.lo[a]   = lo_ff[a];
         push_data.hi[a]   = hi_ff[a];
         push_data.frac[a] = frac_ff[a];
      end
   end

endmodule

// ===== rtl/core/pgts_queue.sv =====
// pgts_queue: short command queue between the front and back parts
// depends on pgts_pkg for the entry type and depth

module pgts_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  pgts_pkg::pgts_cmd_type  push_data,
   output logic                    full,
   input  logic                    pop,
   output pgts_pkg::pgts_cmd_type  pop_data,
   output logic                    empty
);
   import pgts_pkg::*;

   pgts_cmd_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from an empty queue");

endmodule

// ===== rtl/core/pgts_back.sv =====
// pgts_back: probe memory, corner read sequencer, shared lerp unit and result register
// depends on pgts_pkg; takes commands from pgts_queue

module pgts_back (
   input  logic                                clock,
   input  logic                                reset,
   output logic                                pop,
   input  pgts_pkg::pgts_cmd_type              pop_data,
   input  logic                                empty,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [pgts_pkg::VALUE_W-1:0] rsp_blended_value
);
   import pgts_pkg::*;

   typedef enum logic {
      B_IDLE,
      B_RUN
   } back_state_type;

   // step schedule of one sample
   localparam logic [3:0] STEP_READS = 4'd8;
   localparam logic [3:0] STEP_Y0    = 4'd5;
   localparam logic [3:0] STEP_Y1    = 4'd9;
   localparam logic [3:0] STEP_Z     = 4'd10;

   function automatic logic signed [VALUE_W-1:0] lerp16(input logic signed [VALUE_W-1:0] a,
                                                        input logic signed [VALUE_W-1:0] b,
                                                        input logic [FRAC_W-1:0] f);
      logic signed [VALUE_W:0]     d;
      logic signed [VALUE_W+17:0]  p;
      d = (VALUE_W+1)'(b) - (VALUE_W+1)'(a);
      p = d * $signed({1'b0, f});
      return a + VALUE_W'(p >>> FRAC_W);
   endfunction

   back_state_type state_ff, state_in;
   logic [3:0]     step_ff, step_in;
   pgts_cmd_type   cmd_ff;

   logic [VALUE_W-1:0]        probe_store_ff [STORE_DEPTH];
   logic signed [VALUE_W-1:0] rdata_ff;
   logic signed [VALUE_W-1:0] hold_ff;
   logic signed [VALUE_W-1:0] xl_ff [4];
   logic signed [VALUE_W-1:0] yl_ff [2];
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff;

   logic                mem_we, mem_re;
   logic [ADDR_W-1:0]   mem_addr;
   logic [COORD_W-1:0]  cx, cy, cz;
   logic [31:0]         lin_full;
   logic [PROBE_W-1:0]  lin;
   logic                out_free, rsp_load;
   logic signed [VALUE_W-1:0] lerp_a, lerp_b, lerp_out;
   logic [FRAC_W-1:0]   lerp_f;
   logic [1:0]          xl_idx;
   logic                is_x_step;

   assign pop      = (state_ff == B_IDLE) && !empty;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = (state_ff == B_RUN) && (step_ff == STEP_Z) && out_free;

   // corner address: step bits pick the high or low coordinate per axis
   assign cx = step_ff[0] ? cmd_ff.hi[0] : cmd_ff.lo[0];
   assign cy = step_ff[1] ? cmd_ff.hi[1] : cmd_ff.lo[1];
   assign cz = step_ff[2] ? cmd_ff.hi[2] : cmd_ff.lo[2];
   assign lin_full = 32'(cx) + 32'(cy) * 32'(GRID_X) + 32'(cz) * 32'(GRID_X * GRID_Y);
   assign lin      = lin_full[PROBE_W-1:0];

   assign mem_we = pop && (pop_data.kind == KIND_WRITE);
   assign mem_re = (state_ff == B_RUN) && (step_ff < STEP_READS);
   assign mem_addr = mem_we ? {pop_data.probe_index, pop_data.chan} : {lin, cmd_ff.chan};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         probe_store_ff[mem_addr] <= pop_data.write_value;
      end else if (mem_re) begin
         rdata_ff <= $signed(probe_store_ff[mem_addr]);
      end
   end

   // lerp operand selection; x blends on even steps as odd corners arrive
   assign is_x_step = (step_ff == 4'd2) || (step_ff == 4'd4) || (step_ff == 4'd6)
                   || (step_ff == 4'd8);
   assign xl_idx    = 2'((step_ff >> 1) - 4'd1);

   always_comb begin
      lerp_a = hold_ff;
      lerp_b = rdata_ff;
      lerp_f = cmd_ff.frac[0];
      priority if (step_ff == STEP_Y0) begin
         lerp_a = xl_ff[0];
         lerp_b = xl_ff[1];
         lerp_f = cmd_ff.frac[1];
      end else if (step_ff == STEP_Y1) begin
         lerp_a = xl_ff[2];
         lerp_b = xl_ff[3];
         lerp_f = cmd_ff.frac[1];
      end else if (step_ff == STEP_Z) begin
         lerp_a = yl_ff[0];
         lerp_b = yl_ff[1];
         lerp_f = cmd_ff.frac[2];
      end else begin
         lerp_a = hold_ff;
         lerp_b = rdata_ff;
         lerp_f = cmd_ff.frac[0];
      end
   end

   assign lerp_out = lerp16(lerp_a, lerp_b, lerp_f);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (pop && (pop_data.kind == KIND_SAMPLE)) begin
               state_in = B_RUN;
               step_in  = 4'd0;
            end
         end
         B_RUN: begin
            if (step_ff == STEP_Z) begin
               if (out_free) begin
                  state_in = B_IDLE;
               end
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         step_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && (pop_data.kind == KIND_SAMPLE)) begin
         cmd_ff <= pop_data;
      end
      if (state_ff == B_RUN) begin
         if (step_ff[0] && (step_ff < STEP_Y1)) begin
            hold_ff <= rdata_ff;
         end
         if (is_x_step) begin
            xl_ff[xl_idx] <= lerp_out;
         end
         if (step_ff == STEP_Y0) begin
            yl_ff[0] <= lerp_out;
         end
         if (step_ff == STEP_Y1) begin
            yl_ff[1] <= lerp_out;
         end
      end
      if (rsp_load) begin
         rsp_value_ff <= lerp_out;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_blended_value = rsp_value_ff;

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_RUN) |-> (step_ff <= STEP_Z))
      else $error("sample step beyond schedule");

   a_no_pop_while_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_RUN) |-> !pop)
      else $error("command taken while a sample is in progress");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_value_ff)))
      else $error("stalled result overwritten");

   a_write_not_run: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !mem_re)
      else $error("memory port driven twice");

endmodule

// ===== rtl/core/probe_grid_trilinear_sampler.sv =====
// probe_grid_trilinear_sampler: top level of the probe grid trilinear sampler
// depends on pgts_pkg, pgts_front, pgts_queue and pgts_back
//
// usage
//   request channel (req_*): valid/stall. kind 0 stores write_value as channel word
//   channel of probe probe_index; kind 1 samples channel at position pos_x/y/z.
//   result channel (rsp_*): one blended_value per sample request, none per write,
//   in request order. csr_* writes origin and cells-per-unit registers (index 0..5);
//   the user must write them only while the block is idle; the block does not enforce it.
//   front: a sample request occupies it from accept to next accept (subtract, one
//   shared multiplier over the three axes, clamp, push), a write only for the push;
//   each is pushed into a 4-entry command queue, and the push waits while it is full.
//   back: a write goes straight into the single-ported probe memory as it is popped;
//   a sample makes eight corner reads, one per cycle, with the shared lerp unit
//   blending x pairs as they arrive, then y and z. the back part pops no new command
//   until a sample's result is loaded, so the memory port and the lerp chain behind
//   it set the sustained rate.
//   reset clears control state and sets origin to 0 and cells-per-unit to 1.0;
//   the probe memory is not cleared and holds unknown values until written.
//   a stalled result holds in the output register; the back part waits on it and
//   the queue and front keep taking requests until the queue fills.

module probe_grid_trilinear_sampler (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_en,
   input  logic [pgts_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pgts_pkg::CSR_DATA_W-1:0]        csr_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_kind,
   input  logic signed [pgts_pkg::POS_W-1:0]      req_pos_x,
   input  logic signed [pgts_pkg::POS_W-1:0]      req_pos_y,
   input  logic signed [pgts_pkg::POS_W-1:0]      req_pos_z,
   input  logic [pgts_pkg::CHAN_W-1:0]            req_channel,
   input  logic [pgts_pkg::PROBE_W-1:0]           req_probe_index,
   input  logic signed [pgts_pkg::VALUE_W-1:0]    req_write_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [pgts_pkg::VALUE_W-1:0]    rsp_blended_value
);
   import pgts_pkg::*;

   // front to queue
   logic         q_push;
   logic         q_full;
   pgts_cmd_type q_push_data;

   // queue to back
   logic         q_pop;
   logic         q_empty;
   pgts_cmd_type q_pop_data;

   // request intake and coordinate setup
   pgts_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_channel     (req_channel),
      .req_probe_index (req_probe_index),
      .req_write_value (req_write_value),
      .push            (q_push),
      .push_data       (q_push_data),
      .full            (q_full)
   );

   // decouples setup from memory work
   pgts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   // probe memory, corner reads and blending
   pgts_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop               (q_pop),
      .pop_data          (q_pop_data),
      .empty             (q_empty),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_blended_value (rsp_blended_value)
   );

endmodule

// ===== verif/probe_grid_trilinear_sampler_tb.sv =====
// probe_grid_trilinear_sampler_tb: self-checking bench for the probe grid trilinear sampler
// drives probe word writes and grid samples, predicts every blended value in the bench
// depends on pgts_pkg and probe_grid_trilinear_sampler

module probe_grid_trilinear_sampler_tb;
   import pgts_pkg::*;

   // register indexes past the end of the list, writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   // cycles to let the block finish trailing writes
   localparam int SETTLE_CYCLES   = 40;
   // cycles without any handshake before the run is declared hung
   localparam int STALL_LIMIT     = 2000;
   localparam int RANDOM_REQUESTS = 950;
   localparam int RANDOM_PHASES   = 4;

   localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
   localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7fff_ffff;

   // clock, reset and all block inputs known from time zero
   logic                        clock           = 1'b0;
   logic                        reset           = 1'b1;
   logic                        csr_write_en    = 1'b0;
   logic [CSR_INDEX_W-1:0]      csr_index       = '0;
   logic [CSR_DATA_W-1:0]       csr_data        = '0;
   logic                        req_valid       = 1'b0;
   logic                        req_stall;
   logic                        req_kind        = KIND_WRITE;
   logic signed [POS_W-1:0]     req_pos_x       = '0;
   logic signed [POS_W-1:0]     req_pos_y       = '0;
   logic signed [POS_W-1:0]     req_pos_z       = '0;
   logic [CHAN_W-1:0]           req_channel     = '0;
   logic [PROBE_W-1:0]          req_probe_index = '0;
   logic signed [VALUE_W-1:0]   req_write_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall       = 1'b0;
   logic signed [VALUE_W-1:0]   rsp_blended_value;

   // bench copy of the block state: registers and the probe words written so far
   logic signed [POS_W-1:0]     grid_origin [3] = '{'0, '0, '0};
   logic [CPU_W-1:0]            grid_cells  [3] = '{CPU_RESET, CPU_RESET, CPU_RESET};
   logic signed [VALUE_W-1:0]   probe_words [STORE_DEPTH];
   bit                          word_written [STORE_DEPTH];

   // blended values still owed by the block, oldest first
   logic signed [VALUE_W-1:0]   pending_blends [$];

   int  requests_sent = 0;
   int  error_count   = 0;
   int  idle_cycles   = 0;
   // when set, neither side inserts idle cycles
   bit  steady        = 1'b0;

   probe_grid_trilinear_sampler dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_channel       (req_channel),
      .req_probe_index   (req_probe_index),
      .req_write_value   (req_write_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_blended_value (rsp_blended_value)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   // grid-space coordinate of one axis: (pos - origin) * cells + 0.5 in Q.32
   function automatic void map_axis(input logic signed [POS_W-1:0] pos,
                                    input logic signed [POS_W-1:0] org,
                                    input logic [CPU_W-1:0] cells,
                                    output longint whole, output logic [FRAC_W-1:0] frac);
      longint offset;
      longint coord;
      offset = longint'(pos) - longint'(org);
      coord  = offset * longint'(cells) + 64'sh8000_0000;
      // arithmetic shift of a signed value is a floor
      whole  = coord >>> 32;
      frac   = coord[FRAC_W+15:16];
   endfunction

   function automatic int clamp_cell(input longint whole, input int size);
      if (whole < 0) return 0;
      if (whole > size - 1) return size - 1;
      return int'(whole);
   endfunction

   // store addresses of the eight corners, bit 0 steps x, bit 1 y, bit 2 z
   function automatic void locate_corners(input logic signed [POS_W-1:0] px, py, pz,
                                          input logic [CHAN_W-1:0] chan,
                                          output logic [7:0][ADDR_W-1:0] corners,
                                          output logic [2:0][FRAC_W-1:0] fracs);
      longint cx, cy, cz;
      logic [FRAC_W-1:0] fx, fy, fz;
      int x, y, z;
      logic [31:0] lin;
      map_axis(px, grid_origin[0], grid_cells[0], cx, fx);
      map_axis(py, grid_origin[1], grid_cells[1], cy, fy);
      map_axis(pz, grid_origin[2], grid_cells[2], cz, fz);
      for (int i = 0; i < 8; i++) begin
         x = clamp_cell(cx + (i & 1), GRID_X);
         y = clamp_cell(cy + ((i >> 1) & 1), GRID_Y);
         z = clamp_cell(cz + ((i >> 2) & 1), GRID_Z);
         lin = x + y * GRID_X + z * GRID_X * GRID_Y;
         // linear index wraps to the probe field width
         corners[i] = {lin[PROBE_W-1:0], chan};
      end
      fracs = {fz, fy, fx};
   endfunction

   function automatic logic signed [VALUE_W-1:0] lerp_word(input logic signed [VALUE_W-1:0] a,
                                                          input logic signed [VALUE_W-1:0] b,
                                                          input logic [FRAC_W-1:0] f);
      longint scaled;
      scaled = (longint'(b) - longint'(a)) * longint'(f);
      return VALUE_W'(longint'(a) + (scaled >>> 16));
   endfunction

   function automatic logic signed [VALUE_W-1:0] predict_blend(
         input logic signed [POS_W-1:0] px, py, pz, input logic [CHAN_W-1:0] chan);
      logic [7:0][ADDR_W-1:0] corners;
      logic [2:0][FRAC_W-1:0] fracs;
      logic signed [VALUE_W-1:0] v [8];
      logic signed [VALUE_W-1:0] y0, y1, z0, z1;
      locate_corners(px, py, pz, chan, corners, fracs);
      for (int i = 0; i < 8; i++) v[i] = probe_words[corners[i]];
      // x pairs first, then y, then z
      y0 = lerp_word(v[0], v[1], fracs[0]);
      y1 = lerp_word(v[2], v[3], fracs[0]);
      z0 = lerp_word(v[4], v[5], fracs[0]);
      z1 = lerp_word(v[6], v[7], fracs[0]);
      y0 = lerp_word(y0, y1, fracs[1]);
      z0 = lerp_word(z0, z1, fracs[1]);
      return lerp_word(y0, z0, fracs[2]);
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   function automatic int draw_gap();
      return steady ? 0 : $urandom_range(0, 4);
   endfunction

   // present one request, hold it until accepted, then update the bench state
   task automatic issue_request(input logic kind,
                                input logic signed [POS_W-1:0] px, py, pz,
                                input logic [CHAN_W-1:0] chan,
                                input logic [PROBE_W-1:0] probe,
                                input logic signed [VALUE_W-1:0] value);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_pos_x       <= px;
      req_pos_y       <= py;
      req_pos_z       <= pz;
      req_channel     <= chan;
      req_probe_index <= probe;
      req_write_value <= value;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      if (kind == KIND_WRITE) begin
         probe_words[{probe, chan}]  = value;
         word_written[{probe, chan}] = 1'b1;
      end else begin
         pending_blends.push_back(predict_blend(px, py, pz, chan));
      end
   endtask

   // write request with the sample-only fields left random
   task automatic store_word(input logic [PROBE_W-1:0] probe, input logic [CHAN_W-1:0] chan,
                             input logic signed [VALUE_W-1:0] value);
      issue_request(KIND_WRITE, $urandom, $urandom, $urandom, chan, probe, value);
   endtask

   // sample request, preceded by random writes to any corner word not yet written
   task automatic sample_grid(input logic signed [POS_W-1:0] px, py, pz,
                              input logic [CHAN_W-1:0] chan);
      logic [7:0][ADDR_W-1:0] corners;
      logic [2:0][FRAC_W-1:0] fracs;
      locate_corners(px, py, pz, chan, corners, fracs);
      for (int i = 0; i < 8; i++) begin
         if (!word_written[corners[i]])
            store_word(corners[i][ADDR_W-1:CHAN_W], chan, VALUE_W'($urandom));
      end
      issue_request(KIND_SAMPLE, px, py, pz, chan, PROBE_W'($urandom), VALUE_W'($urandom));
   endtask

   // drop valid, wait for every owed result, then let trailing writes finish
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_blends.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one register write per cycle, enable left high for the next one
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_data     <= data;
      @(posedge clock);
      case (index)
         CSR_ORIGIN_X: grid_origin[0] = data;
         CSR_ORIGIN_Y: grid_origin[1] = data;
         CSR_ORIGIN_Z: grid_origin[2] = data;
         CSR_CPU_X:    grid_cells[0]  = data[CPU_W-1:0];
         CSR_CPU_Y:    grid_cells[1]  = data[CPU_W-1:0];
         CSR_CPU_Z:    grid_cells[2]  = data[CPU_W-1:0];
         default: ;
      endcase
   endtask

   // full register set, junk in the unused high byte of the cell registers,
   // plus one write to an index past the end that must change nothing
   task automatic program_grid(input logic signed [POS_W-1:0] ox, oy, oz,
                               input logic [CPU_W-1:0] cx, cy, cz);
      settle_block();
      write_register(CSR_ORIGIN_X, ox);
      write_register(CSR_ORIGIN_Y, oy);
      write_register(CSR_ORIGIN_Z, oz);
      write_register(CSR_CPU_X, {8'($urandom), cx});
      write_register(CSR_CPU_Y, {8'($urandom), cy});
      write_register(CSR_CPU_Z, {8'($urandom), cz});
      write_register($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO, $urandom);
      csr_write_en <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // result side: per-result stall, then compare with the oldest prediction
   // ------------------------------------------------------------------

   initial begin
      int gap;
      logic signed [VALUE_W-1:0] want;
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         if (pending_blends.size() == 0) begin
            $error("blended_value with no sample outstanding: actual %0d", rsp_blended_value);
            error_count++;
         end else begin
            want = pending_blends.pop_front();
            if (rsp_blended_value !== want) begin
               $error("blended_value mismatch: expected %0d, actual %0d",
                      want, rsp_blended_value);
               error_count++;
            end
         end
      end
   end

   // hang detection: any handshake or register write counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $error("no handshake for %0d cycles, %0d results outstanding",
                STALL_LIMIT, pending_blends.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // most negative and most positive words blended with the largest fraction,
   // in both directions, and a sample landing exactly on a probe
   task automatic check_value_extremes();
      store_word(12'd0, 5'd0, 16'sh8000);
      store_word(12'd1, 5'd0, 16'sh7fff);
      // x lands at 0 + 0xffff/65536, y and z clamp to the low edge
      sample_grid(32'sh0000_7fff, POS_MIN, POS_MIN, 5'd0);
      sample_grid(-32'sd32768, POS_MIN, POS_MIN, 5'd0);
      store_word(12'd0, 5'd0, 16'sh7fff);
      store_word(12'd1, 5'd0, 16'sh8000);
      sample_grid(32'sh0000_7fff, POS_MIN, POS_MIN, 5'd0);
   endtask

   // positions far outside the grid saturate corners to the edges; one sample keeps z inside
   task automatic check_clamping();
      sample_grid(POS_MAX, POS_MAX, POS_MAX, 5'd0);
      sample_grid(POS_MAX, POS_MIN, 32'sh0008_4000, 5'd0);
      sample_grid(POS_MIN, POS_MAX, POS_MIN, 5'd0);
   endtask

   // last probe with the last channel word, and a channel beyond the used directions
   task automatic check_top_channel();
      store_word(12'hfff, 5'd31, 16'sh7fff);
      sample_grid(POS_MAX, POS_MAX, POS_MAX, 5'd31);
      sample_grid(32'sh0007_4000, 32'sh000c_c000, 32'sh0002_0001, 5'd31);
   endtask

   // register extremes: lowest origin with the largest scale, then highest
   // origin with zero scale, where every position maps to coordinate 0.5
   task automatic check_register_extremes();
      program_grid(POS_MIN, POS_MIN, POS_MIN, 24'hff_ffff, 24'hff_ffff, 24'hff_ffff);
      sample_grid(POS_MAX, POS_MAX, POS_MAX, 5'd0);
      sample_grid(POS_MIN, POS_MIN, POS_MIN, 5'd0);
      program_grid(POS_MAX, POS_MAX, POS_MAX, 24'h00_0000, 24'h00_0000, 24'h00_0000);
      sample_grid($urandom, $urandom, $urandom, 5'd0);
      sample_grid(POS_MIN, POS_MAX, $urandom, 5'd0);
   endtask

   function automatic logic signed [POS_W-1:0] random_origin();
      return POS_W'(longint'($urandom_range(0, 32'h0200_0000)) - 64'sh0100_0000);
   endfunction

   function automatic logic [CPU_W-1:0] random_cells();
      case ($urandom_range(0, 3))
         0:       return CPU_RESET;
         1:       return 24'h00_8000;
         2:       return 24'h02_0000;
         default: return CPU_W'($urandom_range(24'h00_1000, 24'h04_0000));
      endcase
   endfunction

   // position whose grid coordinate lies between about -0.5 and 17.5, a little past either grid edge
   function automatic logic signed [POS_W-1:0] aim_axis(input int axis);
      longint unit_span;
      longint offset;
      if (grid_cells[axis] == 0) return $urandom;
      unit_span = 64'sh1_0000_0000 / longint'(grid_cells[axis]);
      offset = longint'($urandom_range(0, 32'(18 * unit_span))) - unit_span;
      return POS_W'(longint'(grid_origin[axis]) + offset);
   endfunction

   // mostly samples aimed into the grid, some random writes and some wild positions;
   // idle and steady stretches alternate, one phase pauses until all results are in
   task automatic run_random_traffic(input int budget);
      int phase_end;
      int choice;
      bit drained;
      drained = 1'b0;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         program_grid(random_origin(), random_origin(), random_origin(),
                      random_cells(), random_cells(), random_cells());
         phase_end = requests_sent + budget / RANDOM_PHASES;
         while (requests_sent < phase_end) begin
            if ($urandom_range(0, 49) == 0) steady = !steady;
            if (phase == 1 && !drained && requests_sent >= phase_end - budget / 8) begin
               settle_block();
               drained = 1'b1;
            end
            choice = $urandom_range(0, 9);
            if (choice < 3)
               store_word(PROBE_W'($urandom), CHAN_W'($urandom), VALUE_W'($urandom));
            else if (choice == 3)
               sample_grid($urandom, $urandom, $urandom, CHAN_W'($urandom));
            else
               sample_grid(aim_axis(0), aim_axis(1), aim_axis(2), CHAN_W'($urandom));
         end
      end
      steady = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // reset values of the registers are used by the first tests
      check_value_extremes();
      check_clamping();
      check_top_channel();
      check_register_extremes();
      run_random_traffic(RANDOM_REQUESTS);
      settle_block();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
